>>> rtl/core/spq_pkg.sv
// Package for the sorted priority queue: sizes, operation and status codes,
// and the command struct broadcast from the top level to every cell.
// No dependencies.
package spq_pkg;

    // Number of cells in the chain (legal range 2 to 1024)
    localparam int QUEUE_DEPTH = 128;
    // Width of the fill counter, wide enough to hold QUEUE_DEPTH itself
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int COUNT_OUT_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_DELETE = 2'd2
    } func_e_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_e_t;

    // Command seen by every cell in the cycle an item is applied
    typedef struct packed {
        logic                    en_insert;
        logic                    en_pop;
        logic                    en_delete;
        logic signed [VAL_W-1:0] value;
        logic                    found;
    } cell_cmd_t;

endpackage

>>> rtl/core/spq_cell.sv
// One cell of the sorted chain: holds one entry and its local compares.
// Depends on spq_pkg.
module spq_cell (
    input  logic                             aclk,
    input  spq_pkg::cell_cmd_t               cmd,
    input  logic                             occ,
    input  logic                             ins_left,
    input  logic signed [spq_pkg::VAL_W-1:0] entry_left,
    input  logic signed [spq_pkg::VAL_W-1:0] entry_right,
    output logic                             ins_flag,
    output logic                             eq_flag,
    output logic signed [spq_pkg::VAL_W-1:0] entry
);
    import spq_pkg::*;

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    le_flag;

    // Local compares against the broadcast value
    assign ins_flag = !occ || (cmd.value >= entry_reg);
    assign eq_flag  = occ && (entry_reg == cmd.value);
    assign le_flag  = !occ || (entry_reg <= cmd.value);
    assign entry    = entry_reg;

    // Next entry: shift toward the tail on insert, toward the head on removal
    always_comb begin
        entry_next = entry_reg;
        if (cmd.en_insert) begin
            if (ins_left) begin
                entry_next = entry_left;
            end else if (ins_flag) begin
                entry_next = cmd.value;
            end
        end else if (cmd.en_pop) begin
            entry_next = entry_right;
        end else if (cmd.en_delete && cmd.found && le_flag) begin
            entry_next = entry_right;
        end
    end

    // Payload register, no reset: only entries below the count are read
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/core/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: command decode, fill counter,
// cell chain and result register. Depends on spq_pkg and spq_cell.
//
// Keeps up to QUEUE_DEPTH signed 32-bit values in descending order, largest
// at cell 0. On insert, pop or delete, every cell compares the item's value
// against its own entry in parallel and then loads from its left neighbor,
// its right neighbor, the value or itself. One item is taken per cycle as
// long as the result register is free or being drained; the registered
// result appears in the cycle after acceptance. The delete path (a compare in
// every cell and an OR over all cells to find a match) sets the cycle time.
// No clearing pass is needed after reset: the queue is usable at once.
module sorted_priority_queue_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [spq_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [spq_pkg::VAL_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [spq_pkg::STAT_W-1:0]         m_status,
    output logic signed [spq_pkg::VAL_W-1:0]   m_popped_value,
    output logic [spq_pkg::COUNT_OUT_W-1:0]    m_entry_count
);
    import spq_pkg::*;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [STAT_W-1:0]       m_status_reg;
    logic [STAT_W-1:0]       m_status_next;
    logic signed [VAL_W-1:0] m_popped_reg;
    logic signed [VAL_W-1:0] m_popped_next;
    logic [COUNT_OUT_W-1:0]  m_count_reg;
    logic [COUNT_OUT_W-1:0]  m_count_next;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    found;
    cell_cmd_t               cmd;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    logic [QUEUE_DEPTH-1:0]  occ_vec;
    logic [QUEUE_DEPTH-1:0]  ins_vec;
    logic [QUEUE_DEPTH-1:0]  eq_vec;
    logic signed [VAL_W-1:0] entries [QUEUE_DEPTH];

    assign accept = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign found = |eq_vec;

    // Command broadcast to the chain
    always_comb begin
        cmd.value     = s_value;
        cmd.found     = found;
        cmd.en_insert = accept && (s_func == FUNC_INSERT) && !full;
        cmd.en_pop    = accept && (s_func == FUNC_POP) && !empty;
        cmd.en_delete = accept && (s_func == FUNC_DELETE) && found;
    end

    // Cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                    ins_left;
        logic signed [VAL_W-1:0] entry_left;
        logic signed [VAL_W-1:0] entry_right;

        assign occ_vec[i] = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_head
            assign ins_left   = 1'b0;
            assign entry_left = s_value;
        end else begin : g_body
            assign ins_left   = ins_vec[i-1];
            assign entry_left = entries[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign entry_right = entries[i];
        end else begin : g_inner
            assign entry_right = entries[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occ         (occ_vec[i]),
            .ins_left    (ins_left),
            .entry_left  (entry_left),
            .entry_right (entry_right),
            .ins_flag    (ins_vec[i]),
            .eq_flag     (eq_vec[i]),
            .entry       (entries[i])
        );
    end

    // Result and fill count for the item being accepted
    always_comb begin
        count_next    = count_reg;
        m_status_next = m_status_reg;
        m_popped_next = m_popped_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next  = 1'b1;
            m_status_next = ST_OK;
            m_popped_next = '0;
            case (s_func)
                FUNC_INSERT: begin
                    if (full) begin
                        m_status_next = ST_OVERFLOW;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (empty) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        m_popped_next = entries[0];
                        count_next    = count_reg - 1'b1;
                    end
                end
                FUNC_DELETE: begin
                    if (empty) begin
                        m_status_next = ST_EMPTY;
                    end else if (!found) begin
                        m_status_next = ST_NOT_FOUND;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    m_status_next = ST_OK;
                end
            endcase
        end
    end

    // Reported count wraps to 8 bits
    assign count_wide   = {{COUNT_OUT_W{1'b0}}, count_next};
    assign m_count_next = accept ? count_wide[COUNT_OUT_W-1:0] : m_count_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_popped_reg <= m_popped_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_popped_value = m_popped_reg;
    assign m_entry_count  = m_count_reg;

endmodule

>>> rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top.
module spq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [spq_pkg::FUNC_W-1:0]         s_func,
    input logic signed [spq_pkg::VAL_W-1:0]   s_value,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [spq_pkg::STAT_W-1:0]         m_status,
    input logic signed [spq_pkg::VAL_W-1:0]   m_popped_value,
    input logic [spq_pkg::COUNT_OUT_W-1:0]    m_entry_count
);
    import spq_pkg::*;

    localparam logic [CNT_W+COUNT_OUT_W-1:0] FULL_WIDE =
        (CNT_W+COUNT_OUT_W)'(QUEUE_DEPTH);
    localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = FULL_WIDE[COUNT_OUT_W-1:0];

    // Result register is empty after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A held result blocks new items
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("item accepted while result stalled");

    // Empty status only with nothing stored and nothing popped
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_entry_count == '0 && m_popped_value == '0))
        else $error("empty status with nonzero count or value");

    // Overflow only when the queue is full
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OVERFLOW) |-> (m_entry_count == FULL_COUNT))
        else $error("overflow with queue not full");

    // A nonzero popped value comes only with an OK status
    a_popped_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_popped_value != '0) |-> (m_status == ST_OK))
        else $error("popped value with error status");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_func         (s_func),
    .s_value        (s_value),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_popped_value (m_popped_value),
    .m_entry_count  (m_entry_count)
);
